>>> rtl/edfs_pkg.sv
// edfs_pkg: shared types, widths and codes of the deadline-sorted frame scheduler
// no dependencies; imported by every module and interface of the block
`timescale 1ns / 1ps

package edfs_pkg;

	localparam int SLOTS   = 16;
	localparam int OCC_W   = $clog2(SLOTS + 1);

	localparam int PTS_W   = 33;
	localparam int TAG_W   = 32;
	localparam int DL_W    = 47;
	localparam int CFG_W   = 32;
	localparam int CNT_W   = 32;
	localparam int STAT_W  = 3;

	// deadline = pts * 100000 / 9 = pts * 11111 + pts / 9, since 100000 = 9 * 11111 + 1
	localparam int DL_DIVISOR   = 9;
	localparam int DL_SCALE_INT = 100000 / DL_DIVISOR;

	// pts / 9 as (pts * ceil(2^35 / 9)) >> 35, exact for every 33-bit pts
	localparam int RECIP_W      = 32;
	localparam int RECIP_SH     = 35;
	localparam int RECIP_SPLIT  = 16;
	localparam int RECIP_LO_W   = RECIP_SPLIT + RECIP_W;
	localparam int RECIP_HI_W   = PTS_W - RECIP_SPLIT + RECIP_W;
	localparam int RECIP_PROD_W = PTS_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DL_RECIP =
		RECIP_W'((64'd1 << RECIP_SH) / 64'(DL_DIVISOR) + 64'd1);

	localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(200000000);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STAT_W-1:0] ST_PUSHED    = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_PRESENTED = 3'd2;
	localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_READY = 3'd4;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

	typedef struct packed {
		logic [DL_W-1:0]  deadline;
		logic [PTS_W-1:0] pts;
		logic [TAG_W-1:0] tag;
		logic             kind;
	} entry_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t new_entry;
	} cell_cmd_t;

endpackage

>>> rtl/edfs_if.sv
// edfs_req_if / edfs_rsp_if: valid/ready channels for requests and results
// depends on edfs_pkg for field widths
`timescale 1ns / 1ps

interface edfs_req_if;
	import edfs_pkg::*;

	logic             valid;
	logic             ready;
	logic             op;
	logic [PTS_W-1:0] frame_pts;
	logic [TAG_W-1:0] frame_tag;
	logic             stream_kind;
	logic [DL_W-1:0]  now_ns;

	modport source (output valid, output op, output frame_pts, output frame_tag,
		output stream_kind, output now_ns, input ready);
	modport sink (input valid, input op, input frame_pts, input frame_tag,
		input stream_kind, input now_ns, output ready);
endinterface

interface edfs_rsp_if;
	import edfs_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [PTS_W-1:0]  out_pts;
	logic [TAG_W-1:0]  out_tag;
	logic              out_stream_kind;
	logic [CNT_W-1:0]  presented_total;
	logic [CNT_W-1:0]  dropped_total;

	modport source (output valid, output status, output out_pts, output out_tag,
		output out_stream_kind, output presented_total, output dropped_total,
		input ready);
	modport sink (input valid, input status, input out_pts, input out_tag,
		input out_stream_kind, input presented_total, input dropped_total,
		output ready);
endinterface

>>> rtl/edfs_cell.sv
// edfs_cell: one slot of the sorted table, shifts right on insert and left on removal
// depends on edfs_pkg
`timescale 1ns / 1ps

module edfs_cell (
	input  logic               clk,
	input  edfs_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  logic               at_tail,
	input  logic               prev_lt,
	input  edfs_pkg::entry_t   prev_entry,
	input  edfs_pkg::entry_t   next_entry,
	output logic               lt,
	output edfs_pkg::entry_t   entry
);
	import edfs_pkg::*;

	entry_t entry_q;

	// new deadline sorts before this slot; monotonic along the occupied part
	assign lt    = occupied && (cmd.new_entry.deadline < entry_q.deadline);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (prev_lt) begin
				entry_q <= prev_entry;
			end else if (lt || at_tail) begin
				entry_q <= cmd.new_entry;
			end
		end else if (cmd.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

>>> rtl/edfs_dl_unit.sv
// edfs_dl_unit: pts to nanosecond deadline, pts*11111 plus pts/9 by reciprocal multiply
// depends on edfs_pkg
`timescale 1ns / 1ps

module edfs_dl_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [edfs_pkg::PTS_W-1:0] pts,
	output logic                       done,
	output logic [edfs_pkg::DL_W-1:0]  dl
);
	import edfs_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LO   = 2'd1;
	localparam logic [1:0] PH_HI   = 2'd2;
	localparam logic [1:0] PH_ADD  = 2'd3;

	logic [1:0]              phase_q;
	logic                    done_q;
	logic [PTS_W-1:0]        pts_q;
	logic [DL_W-1:0]         mul_q;
	logic [DL_W-1:0]         dl_q;
	logic [RECIP_PROD_W-1:0] acc_q;
	logic [RECIP_LO_W-1:0]   prod_lo;
	logic [RECIP_HI_W-1:0]   prod_hi;

	// two partial products of pts times the reciprocal, one per cycle
	assign prod_lo = RECIP_LO_W'(pts_q[RECIP_SPLIT-1:0]) * RECIP_LO_W'(DL_RECIP);
	assign prod_hi = RECIP_HI_W'(pts_q[PTS_W-1:RECIP_SPLIT]) * RECIP_HI_W'(DL_RECIP);
	assign done    = done_q;
	assign dl      = dl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_LO;
					end
				end
				PH_LO: begin
					phase_q <= PH_HI;
				end
				PH_HI: begin
					phase_q <= PH_ADD;
				end
				PH_ADD: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			pts_q <= pts;
			mul_q <= DL_W'(pts) * DL_W'(DL_SCALE_INT);
		end else if (phase_q == PH_LO) begin
			acc_q <= RECIP_PROD_W'(prod_lo);
		end else if (phase_q == PH_HI) begin
			// upper partial product lands above the split
			acc_q <= acc_q + {prod_hi, RECIP_SPLIT'(0)};
		end else if (phase_q == PH_ADD) begin
			dl_q <= mul_q + DL_W'(acc_q[RECIP_PROD_W-1:RECIP_SH]);
		end
	end

endmodule

>>> rtl/edf_frame_scheduler_top.sv
// edf_frame_scheduler_top: a push runs from transaction to result through two partial
// products for the divide by nine, the deadline add, a hand-off and an insert; a pop or a
// rejected push skips those steps. one request is in work at a time: a new one is taken
// in the cycle after the result is registered at the earliest; a result still waiting at
// the output holds the request in work at its last step.
// arst_n clears occupancy, counters, handshake state and sets the late limit to 200 ms.
`timescale 1ns / 1ps

module edf_frame_scheduler_top (
	input  logic                      clk,
	input  logic                      arst_n,
	edfs_req_if.sink                  req,
	edfs_rsp_if.source                rsp,
	input  logic                      cfg_we,
	input  logic [edfs_pkg::CFG_W-1:0] cfg_wdata
);
	import edfs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DL   = 2'd1;
	localparam logic [1:0] S_INS  = 2'd2;
	localparam logic [1:0] S_POP  = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PTS_W-1:0]  pts;
		logic [TAG_W-1:0]  tag;
		logic              kind;
		logic [CNT_W-1:0]  presented;
		logic [CNT_W-1:0]  dropped;
	} rsp_t;

	logic [1:0]       state_q;
	logic [OCC_W-1:0] occ_q;
	logic [CFG_W-1:0] limit_q;
	logic [CNT_W-1:0] presented_q;
	logic [CNT_W-1:0] dropped_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic [PTS_W-1:0] pts_q;
	logic [TAG_W-1:0] tag_q;
	logic             kind_q;
	logic [DL_W-1:0]  now_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             out_free;
	logic             emit;
	logic             dl_start;
	logic             dl_done;
	logic [DL_W-1:0]  dl;
	logic [DL_W-1:0]  lateness;
	logic             not_ready;
	logic             late;
	logic [STAT_W-1:0] res_status;
	logic             do_push;
	logic             do_pop;
	logic [CNT_W-1:0] presented_nxt;
	logic [CNT_W-1:0] dropped_nxt;
	entry_t           head;
	cell_cmd_t        cmd;

	entry_t           cell_entry [SLOTS];
	entry_t           cell_prev  [SLOTS];
	entry_t           cell_next  [SLOTS];
	logic [SLOTS-1:0] cell_lt;
	logic [SLOTS-1:0] cell_prev_lt;
	logic [SLOTS-1:0] cell_occ;
	logic [SLOTS-1:0] cell_tail;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign full      = (occ_q == OCC_W'(SLOTS));
	assign empty     = (occ_q == '0);
	assign out_free  = !out_valid_q || rsp.ready;
	assign emit      = out_free && (state_q == S_INS || state_q == S_POP);
	assign dl_start  = accept && (req.op == OP_PUSH) && !full;

	assign head      = cell_entry[0];
	assign lateness  = now_q - head.deadline;
	assign not_ready = now_q < head.deadline;
	assign late      = lateness > DL_W'(limit_q);

	always_comb begin
		res_status = ST_PUSHED;
		if (state_q == S_INS) begin
			res_status = full ? ST_FULL : ST_PUSHED;
		end else if (empty) begin
			res_status = ST_EMPTY;
		end else if (not_ready) begin
			res_status = ST_NOT_READY;
		end else if (late) begin
			res_status = ST_DROPPED;
		end else begin
			res_status = ST_PRESENTED;
		end
	end

	assign do_push = emit && (state_q == S_INS) && !full;
	assign do_pop  = emit && (state_q == S_POP)
		&& (res_status == ST_DROPPED || res_status == ST_PRESENTED);

	assign presented_nxt = presented_q + CNT_W'(do_pop && res_status == ST_PRESENTED);
	assign dropped_nxt   = dropped_q + CNT_W'(do_pop && res_status == ST_DROPPED);

	assign cmd.push               = do_push;
	assign cmd.pop                = do_pop;
	assign cmd.new_entry.deadline = dl;
	assign cmd.new_entry.pts      = pts_q;
	assign cmd.new_entry.tag      = tag_q;
	assign cmd.new_entry.kind     = kind_q;

	edfs_dl_unit u_dl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dl_start),
		.pts    (req.frame_pts),
		.done   (dl_done),
		.dl     (dl)
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		assign cell_occ[i]  = OCC_W'(i) < occ_q;
		assign cell_tail[i] = OCC_W'(i) == occ_q;
		if (i == 0) begin : g_first
			assign cell_prev_lt[i] = 1'b0;
			assign cell_prev[i]    = cmd.new_entry;
		end else begin : g_inner
			assign cell_prev_lt[i] = cell_lt[i-1];
			assign cell_prev[i]    = cell_entry[i-1];
		end
		if (i == SLOTS - 1) begin : g_last
			assign cell_next[i] = cell_entry[i];
		end else begin : g_body
			assign cell_next[i] = cell_entry[i+1];
		end

		edfs_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (cell_occ[i]),
			.at_tail    (cell_tail[i]),
			.prev_lt    (cell_prev_lt[i]),
			.prev_entry (cell_prev[i]),
			.next_entry (cell_next[i]),
			.lt         (cell_lt[i]),
			.entry      (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			limit_q     <= LIMIT_RESET;
			presented_q <= '0;
			dropped_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			presented_q <= presented_nxt;
			dropped_q   <= dropped_nxt;
			if (do_push) begin
				occ_q <= occ_q + 1'b1;
			end else if (do_pop) begin
				occ_q <= occ_q - 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.op == OP_POP) begin
							state_q <= S_POP;
						end else if (full) begin
							state_q <= S_INS;
						end else begin
							state_q <= S_DL;
						end
					end
				end
				S_DL: begin
					if (dl_done) begin
						state_q <= S_INS;
					end
				end
				S_INS, S_POP: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pts_q  <= req.frame_pts;
			tag_q  <= req.frame_tag;
			kind_q <= req.stream_kind;
			now_q  <= req.now_ns;
		end
		if (emit) begin
			out_q.status    <= res_status;
			out_q.pts       <= (res_status == ST_PRESENTED) ? head.pts : '0;
			out_q.tag       <= (res_status == ST_PRESENTED) ? head.tag : '0;
			out_q.kind      <= (res_status == ST_PRESENTED) ? head.kind : 1'b0;
			out_q.presented <= presented_nxt;
			out_q.dropped   <= dropped_nxt;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.out_pts         = out_q.pts;
	assign rsp.out_tag         = out_q.tag;
	assign rsp.out_stream_kind = out_q.kind;
	assign rsp.presented_total = out_q.presented;
	assign rsp.dropped_total   = out_q.dropped;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(SLOTS))
		else $error("occupancy above table size");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == S_INS && res_status == ST_PUSHED) |=> occ_q == $past(occ_q) + 1'b1)
		else $error("accepted push did not add an entry");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == S_POP && (res_status == ST_PRESENTED || res_status == ST_DROPPED))
		|=> occ_q == $past(occ_q) - 1'b1)
		else $error("removal did not drop an entry");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q >= OCC_W'(2) |-> cell_entry[0].deadline <= cell_entry[1].deadline)
		else $error("head entries out of deadline order");

	a_dl_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS || state_q == S_POP) |-> !dl_start)
		else $error("deadline unit started while a request is in work");

endmodule

>>> test/edf_frame_scheduler_top_tb.sv
// testbench for edf_frame_scheduler_top: a directed table, then random push/pop traffic
// checked against a deadline-sorted frame table kept in the bench; depends on edfs_pkg,
// edfs_req_if / edfs_rsp_if and edf_frame_scheduler_top
`timescale 1ns / 1ps

module edf_frame_scheduler_top_tb;
	import edfs_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 4;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 170;
	localparam int QUIET_CYCLES = 16;
	localparam int LONG_HOLD    = 250;
	localparam int STALL_LIMIT  = 2000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PTS_W-1:0]  pts;
		logic [TAG_W-1:0]  tag;
		logic              kind;
		logic [CNT_W-1:0]  presented;
		logic [CNT_W-1:0]  dropped;
	} sched_outcome_t;

	typedef struct {
		logic             op;
		logic [PTS_W-1:0] pts;
		logic [TAG_W-1:0] tag;
		logic             kind;
		logic [DL_W-1:0]  now;
		bit               fixed;
		sched_outcome_t   want;
	} frame_req_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	edfs_req_if req_ch ();
	edfs_rsp_if rsp_ch ();

	edf_frame_scheduler_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// bench copy of the scheduler state
	entry_t           frame_table[$];
	logic [CFG_W-1:0] late_limit = LIMIT_RESET;
	logic [PTS_W-1:0] audio_pts_seen = '0;
	logic [PTS_W-1:0] video_pts_seen = '0;
	logic [CNT_W-1:0] presented_cnt = '0;
	logic [CNT_W-1:0] dropped_cnt = '0;

	sched_outcome_t outcome_q[$];
	frame_req_t     dir_rows[$];

	bit             offered_fixed = 1'b0;
	sched_outcome_t offered_want = '0;
	bit             hold_results = 1'b0;
	int             idle_pct = 20;
	int             stall_pct = 20;
	int             push_pct = 55;
	int             error_count = 0;
	int             stall_cycles = 0;
	logic [63:0]    cursor_tick = 64'd20000;
	logic [PTS_W-1:0] last_push_pts = '0;

	function automatic logic [63:0] deadline_of(input logic [63:0] pts);
		return (pts * 64'd100000) / 64'd9;
	endfunction

	function automatic sched_outcome_t schedule_request(input logic op,
			input logic [PTS_W-1:0] pts, input logic [TAG_W-1:0] tag,
			input logic kind, input logic [DL_W-1:0] now);
		sched_outcome_t o;
		entry_t e;
		int pos;
		o = '0;
		if (op == OP_PUSH) begin
			if (frame_table.size() >= SLOTS) begin
				o.status = ST_FULL;
			end else begin
				e.deadline = DL_W'(deadline_of(pts));
				e.pts = pts;
				e.tag = tag;
				e.kind = kind;
				// equal deadlines go behind the ones already queued
				pos = 0;
				while (pos < frame_table.size() && frame_table[pos].deadline <= e.deadline)
					pos++;
				if (pos == frame_table.size())
					frame_table.push_back(e);
				else
					frame_table.insert(pos, e);
				o.status = ST_PUSHED;
			end
		end else if (frame_table.size() == 0) begin
			o.status = ST_EMPTY;
		end else if (now < frame_table[0].deadline) begin
			o.status = ST_NOT_READY;
		end else if ((now - frame_table[0].deadline) > DL_W'(late_limit)) begin
			dropped_cnt++;
			void'(frame_table.pop_front());
			o.status = ST_DROPPED;
		end else begin
			e = frame_table.pop_front();
			o.pts = e.pts;
			o.tag = e.tag;
			o.kind = e.kind;
			if (e.kind)
				audio_pts_seen = e.pts;
			else
				video_pts_seen = e.pts;
			presented_cnt++;
			o.status = ST_PRESENTED;
		end
		o.presented = presented_cnt;
		o.dropped = dropped_cnt;
		return o;
	endfunction

	function automatic void add_row(input logic op, input logic [PTS_W-1:0] pts,
			input logic [TAG_W-1:0] tag, input logic kind, input logic [DL_W-1:0] now,
			input bit fixed, input logic [STAT_W-1:0] st, input int pres, input int drop);
		frame_req_t r;
		r.op = op;
		r.pts = pts;
		r.tag = tag;
		r.kind = kind;
		r.now = now;
		r.fixed = fixed;
		r.want = '0;
		r.want.status = st;
		r.want.presented = CNT_W'(pres);
		r.want.dropped = CNT_W'(drop);
		dir_rows.push_back(r);
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 35;
		endcase
	endfunction

	task automatic make_random_frame(output frame_req_t f);
		logic [63:0] t;
		logic [63:0] hd;
		f.fixed = 1'b0;
		f.want = '0;
		f.tag = $urandom;
		f.kind = $urandom_range(0, 1);
		f.pts = PTS_W'({$urandom, $urandom});
		f.now = DL_W'({$urandom, $urandom});
		if ($urandom_range(0, 99) < 5) begin
			// noise: any operation with fully random fields
			f.op = $urandom_range(0, 1);
		end else if ($urandom_range(0, 99) < push_pct) begin
			f.op = OP_PUSH;
			if ($urandom_range(0, 4) == 0) begin
				f.pts = last_push_pts;
			end else begin
				t = cursor_tick + $urandom_range(0, 40000) - 8000;
				f.pts = t[PTS_W-1:0];
			end
			last_push_pts = f.pts;
		end else begin
			f.op = OP_POP;
			cursor_tick += $urandom_range(0, 2500);
			t = deadline_of(cursor_tick) + $urandom_range(0, 600_000_000) - 200_000_000;
			// now and then land right on the due and late boundaries of the head
			if (frame_table.size() != 0 && $urandom_range(0, 99) < 15) begin
				hd = 64'(frame_table[0].deadline);
				case ($urandom_range(0, 3))
					0: t = hd - 1;
					1: t = hd;
					2: t = hd + late_limit;
					default: t = hd + late_limit + 1;
				endcase
			end
			f.now = t[DL_W-1:0];
		end
	endtask

	// entered and left just after a falling edge
	task automatic drive_frame(input frame_req_t f);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= f.op;
		req_ch.frame_pts <= f.pts;
		req_ch.frame_tag <= f.tag;
		req_ch.stream_kind <= f.kind;
		req_ch.now_ns <= f.now;
		offered_fixed = f.fixed;
		offered_want = f.want;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0) @(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				hold_results = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		sched_outcome_t got;
		sched_outcome_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				late_limit = cfg_wdata;
				moved = 1'b1;
			end
			if (req_ch.valid && req_ch.ready) begin
				want = schedule_request(req_ch.op, req_ch.frame_pts, req_ch.frame_tag,
					req_ch.stream_kind, req_ch.now_ns);
				if (offered_fixed)
					want = offered_want;
				outcome_q.push_back(want);
				moved = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				moved = 1'b1;
				got.status = rsp_ch.status;
				got.pts = rsp_ch.out_pts;
				got.tag = rsp_ch.out_tag;
				got.kind = rsp_ch.out_stream_kind;
				got.presented = rsp_ch.presented_total;
				got.dropped = rsp_ch.dropped_total;
				if (outcome_q.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("%0t: result with nothing outstanding, status %0d",
							$time, got.status);
				end else begin
					want = outcome_q.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= REPORT_MAX) begin
							$display("%0t: exp st %0d pts %0h tag %0h kd %0b pr %0d dr %0d",
								$time, want.status, want.pts, want.tag, want.kind,
								want.presented, want.dropped);
							$display("%0t: got st %0d pts %0h tag %0h kd %0b pr %0d dr %0d",
								$time, got.status, got.pts, got.tag, got.kind,
								got.presented, got.dropped);
						end
					end
				end
			end
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		frame_req_t f;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PUSH;
		req_ch.frame_pts = '0;
		req_ch.frame_tag = '0;
		req_ch.stream_kind = 1'b0;
		req_ch.now_ns = '0;

		add_row(OP_POP, '0, '0, 1'b0, '0, 1, ST_EMPTY, 0, 0);
		add_row(OP_PUSH, '1, '1, 1'b1, '0, 1, ST_PUSHED, 0, 0);
		add_row(OP_PUSH, '0, '0, 1'b0, '1, 1, ST_PUSHED, 0, 0);
		add_row(OP_POP, '1, '1, 1'b1, '0, 1, ST_PRESENTED, 1, 0);
		add_row(OP_POP, '0, '0, 1'b0, '0, 1, ST_NOT_READY, 1, 0);
		// lateness exactly at the limit is still presented
		add_row(OP_PUSH, 33'd9, 32'h0000_a001, 1'b1, '0, 0, ST_PUSHED, 0, 0);
		add_row(OP_POP, '0, '0, 1'b0, 47'd200_100_000, 0, ST_PUSHED, 0, 0);
		// equal deadlines leave in arrival order, then one past the limit is dropped
		add_row(OP_PUSH, 33'd900, 32'h0000_a002, 1'b0, '0, 0, ST_PUSHED, 0, 0);
		add_row(OP_PUSH, 33'd900, 32'h0000_a003, 1'b1, '0, 0, ST_PUSHED, 0, 0);
		add_row(OP_POP, '0, '0, 1'b0, 47'd10_000_000, 0, ST_PUSHED, 0, 0);
		add_row(OP_POP, '0, '0, 1'b0, 47'd210_000_001, 0, ST_PUSHED, 0, 0);
		for (int i = 1; i < SLOTS; i++)
			add_row(OP_PUSH, PTS_W'(i * 1000), TAG_W'(i), i[0], '0, 0, ST_PUSHED, 0, 0);
		add_row(OP_PUSH, 33'd5, 32'h5a5a_5a5a, 1'b1, '0, 1, ST_FULL, 3, 1);
		add_row(OP_POP, '0, '0, 1'b0, '1, 0, ST_PUSHED, 0, 0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			drive_frame(dir_rows[i]);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: write_limit('0);
				1: write_limit('1);
				2: write_limit(CFG_W'($urandom_range(1000, 100_000_000)));
				3: write_limit($urandom);
				default: write_limit(LIMIT_RESET);
			endcase
			cursor_tick = 64'd20000 + 64'(p) * 64'd1_700_000_000
				+ 64'($urandom_range(0, 1_000_000_000));
			last_push_pts = cursor_tick[PTS_W-1:0];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					case ($urandom_range(0, 2))
						0: push_pct = 35;
						1: push_pct = 55;
						default: push_pct = 80;
					endcase
					idle_pct = pick_idle_pct();
					stall_pct = pick_idle_pct();
				end
				if (p == PHASES - 1) begin
					idle_pct = 0;
					stall_pct = 0;
				end
				// back-pressure long enough to stall the request side
				if (p == 1 && n == 20)
					hold_results = 1'b1;
				if (p == 2 && n == 85)
					wait_drained();
				make_random_frame(f);
				drive_frame(f);
			end
		end

		wait_drained();
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/edfs_pkg.sv
rtl/edfs_if.sv
rtl/edfs_cell.sv
rtl/edfs_dl_unit.sv
rtl/edf_frame_scheduler_top.sv
test/edf_frame_scheduler_top_tb.sv
